// File: design/fit_to_viewport_transform_macros.svh
// ----------------------------------------------------------------------------
// fit_to_viewport_transform_macros.svh
// Assertion macros used by the viewport transform datapath (fvt_dp).
// ----------------------------------------------------------------------------
`ifndef FIT_TO_VIEWPORT_TRANSFORM_MACROS_SVH
`define FIT_TO_VIEWPORT_TRANSFORM_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that post holds in the same cycle as pre
`define FVT_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("viewport transform check failed");
// Check that post holds in the cycle after pre
`define FVT_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("viewport transform check failed");
`else
`define FVT_ASSERT_IMPLY(label, pre, post)
`define FVT_ASSERT_NEXT(label, pre, post)
`endif

`endif

// File: design/fvt_pkg.sv
// ----------------------------------------------------------------------------
// fvt_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fvt_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int COORD_W  = 32;
   localparam int ZOOM_W   = 32;
   localparam int SHIFT_W  = 48;
   localparam int PIX_W    = 16;
   localparam int MARGIN_W = 15;
   localparam int ACT_W    = 3;
   localparam int ST_W     = 3;
   localparam int QUO_W    = 34;  // quotient bits kept, sticky overflow above
   localparam int NUM_W    = 50;  // signed pixel-minus-offset numerator
   localparam int WIDE_W   = 67;  // signed offset and pixel sums
   localparam int MUL_A_W  = 33;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // Actions
   localparam logic [ACT_W-1:0] ACT_ADD   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_FIT   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_W2P   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_P2W   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

   // Status codes
   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_BAD_SIZE = 3'd1;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [ST_W-1:0] ST_DEGEN    = 3'd3;
   localparam logic [ST_W-1:0] ST_NOT_FIT  = 3'd4;
   localparam logic [ST_W-1:0] ST_CLAMP    = 3'd5;

   // Register indexes
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MARGIN = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_DECODE,
      OP_DIV_ZX,
      OP_DIV_ZY,
      OP_DIV_WX,
      OP_DIV_WY,
      OP_TAKE_Z,
      OP_TAKE_WX,
      OP_TAKE_WY,
      OP_MUL_OFFX,
      OP_MUL_OFFY,
      OP_COMMIT,
      OP_MUL_PIXX,
      OP_MUL_PIXY,
      OP_FIN_PIX
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load;
      logic      emit;
   } dp_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             bad_size;
      logic             empty;
      logic             degen;
      logic             ex_nz;
      logic             ey_nz;
      logic             can_map;
      logic             div_done;
      logic             out_free;
   } dp_sts_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_FIT_DX,
      S_FIT_WX,
      S_FIT_DY,
      S_FIT_WY,
      S_FIT_MX,
      S_FIT_MY,
      S_FIT_COMMIT,
      S_W2P_MX,
      S_W2P_MY,
      S_W2P_FIN,
      S_P2W_DX,
      S_P2W_WX,
      S_P2W_DY,
      S_P2W_WY,
      S_DONE
   } ctrl_state_type;

endpackage

// File: design/fvt_div.sv
// ----------------------------------------------------------------------------
// fvt_div
// Restoring divider, one quotient bit per cycle, sticky quotient overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvt_div import fvt_pkg::*; #(
   parameter int DIV_W = 65
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [ZOOM_W-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [ZOOM_W-1:0] dsr_ff, dsr_in;
   logic [ZOOM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              ovf_ff, ovf_in;
   logic [ZOOM_W:0]   trial;
   logic [ZOOM_W:0]   diff;
   logic              ge;

   // One trial subtract per cycle
   always_comb begin
      trial = {rem_ff, dvd_ff[DIV_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = (trial >= {1'b0, dsr_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = ge ? diff[ZOOM_W-1:0] : trial[ZOOM_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         ovf_in = ovf_ff | quo_ff[QUO_W-1];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = ovf_ff ? {QUO_W{1'b1}} : quo_ff;

endmodule

// File: design/fvt_dp.sv
// ----------------------------------------------------------------------------
// fvt_dp
// Datapath: bounding box, fit state, shared divider and multiplier, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fit_to_viewport_transform_macros.svh"

module fvt_dp import fvt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_sts_type                sts,
   input  logic [ACT_W-1:0]          req_action,
   input  logic signed [COORD_W-1:0] req_world_x,
   input  logic signed [COORD_W-1:0] req_world_y,
   input  logic [PIX_W-1:0]          req_pixel_x,
   input  logic [PIX_W-1:0]          req_pixel_y,
   input  logic [PIX_W-1:0]          cfg_width,
   input  logic [PIX_W-1:0]          cfg_height,
   input  logic [MARGIN_W-1:0]       cfg_margin,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_out_world_x,
   output logic signed [COORD_W-1:0] rsp_out_world_y,
   output logic [PIX_W-1:0]          rsp_out_pixel_x,
   output logic [PIX_W-1:0]          rsp_out_pixel_y,
   output logic [ST_W-1:0]           rsp_status
);

   localparam int DW     = NUM_W - 1 + FRAC_BITS;
   localparam int PROD_W = MUL_A_W + ZOOM_W;

   // Latched item
   logic [ACT_W-1:0]          action_ff;
   logic signed [COORD_W-1:0] wx_ff, wy_ff;
   logic [PIX_W-1:0]          px_ff, py_ff;

   // Model state
   logic signed [COORD_W-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic [ZOOM_W-1:0]         scale_ff;
   logic [SHIFT_W-1:0]        shift_x_ff, shift_y_ff;
   logic                      fitted_ff;

   // Work registers
   logic [ZOOM_W-1:0]         ztmp_ff;
   logic [SHIFT_W-1:0]        shx_tmp_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic                      pneg_ff;
   logic                      wneg_ff;
   logic                      flag_ff;

   // Result and output stage
   logic [COORD_W-1:0]        res_wx_ff, res_wy_ff;
   logic [PIX_W-1:0]          res_px_ff, res_py_ff;
   logic [ST_W-1:0]           res_st_ff;
   logic                      rsp_valid_ff;
   logic [COORD_W-1:0]        rsp_wx_ff, rsp_wy_ff;
   logic [PIX_W-1:0]          rsp_px_ff, rsp_py_ff;
   logic [ST_W-1:0]           rsp_st_ff;

   // Fit checks
   logic [PIX_W-1:0]          two_m;
   logic [PIX_W-1:0]          avail_w, avail_h;
   logic [COORD_W-1:0]        ext_x, ext_y;
   logic                      bad_size, empty, ex_nz, ey_nz, can_map;

   always_comb begin
      two_m    = {cfg_margin, 1'b0};
      avail_w  = cfg_width - two_m;
      avail_h  = cfg_height - two_m;
      bad_size = (cfg_width == '0) || (cfg_height == '0) ||
                 (cfg_width <= two_m) || (cfg_height <= two_m);
      empty    = (min_x_ff > max_x_ff) || (min_y_ff > max_y_ff);
      ext_x    = max_x_ff - min_x_ff;
      ext_y    = max_y_ff - min_y_ff;
      ex_nz    = (ext_x != '0);
      ey_nz    = (ext_y != '0);
      can_map  = fitted_ff && (scale_ff != '0);
   end

   // Divider operands
   logic [PIX_W-1:0]   pix_sel;
   logic [SHIFT_W-1:0] dshift_sel;
   logic [NUM_W-1:0]   pix_term, num, mag;
   logic               nneg;
   logic [DW-1:0]      div_dividend;
   logic [ZOOM_W-1:0]  div_divisor;
   logic               div_start, div_busy, div_done;
   logic [QUO_W-1:0]   quotient;

   always_comb begin
      pix_sel    = (cmd.op == OP_DIV_WY) ? py_ff : px_ff;
      dshift_sel = (cmd.op == OP_DIV_WY) ? shift_y_ff : shift_x_ff;
      pix_term   = NUM_W'(pix_sel) << FRAC_BITS;
      num        = pix_term - {{(NUM_W-SHIFT_W){dshift_sel[SHIFT_W-1]}}, dshift_sel};
      nneg       = num[NUM_W-1];
      mag        = nneg ? (~num + NUM_W'(1)) : num;
      div_start  = 1'b0;
      div_dividend = DW'(mag[NUM_W-2:0]) << FRAC_BITS;
      div_divisor  = scale_ff;
      case (cmd.op)
         OP_DIV_ZX: begin
            div_start    = 1'b1;
            div_dividend = DW'(avail_w) << (2 * FRAC_BITS);
            div_divisor  = ext_x;
         end
         OP_DIV_ZY: begin
            div_start    = 1'b1;
            div_dividend = DW'(avail_h) << (2 * FRAC_BITS);
            div_divisor  = ext_y;
         end
         OP_DIV_WX, OP_DIV_WY: begin
            div_start = 1'b1;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   fvt_div #(
      .DIV_W (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   // Zoom from quotient: saturate, never zero
   logic [ZOOM_W-1:0] qz;
   always_comb begin
      qz = (|quotient[QUO_W-1:ZOOM_W]) ? {ZOOM_W{1'b1}} : quotient[ZOOM_W-1:0];
      if (qz == '0) begin
         qz = ZOOM_W'(1);
      end
   end

   // World value from quotient, saturated to signed 32
   logic [COORD_W-1:0] w_val;
   logic               w_sat;
   logic [QUO_W-1:0]   w_neg_raw;
   always_comb begin
      w_neg_raw = ~quotient + QUO_W'(1);
      if (!wneg_ff) begin
         w_sat = (quotient > QUO_W'(32'h7FFF_FFFF));
         w_val = w_sat ? 32'h7FFF_FFFF : quotient[COORD_W-1:0];
      end else begin
         w_sat = (quotient > QUO_W'(32'h8000_0000));
         w_val = w_sat ? 32'h8000_0000 : w_neg_raw[COORD_W-1:0];
      end
   end

   // Multiplier operands
   logic [COORD_W:0]     sum_sel;
   logic [COORD_W-1:0]   w_sel;
   logic [COORD_W-1:0]   w_abs;
   logic [MUL_A_W-1:0]   mul_a;
   logic [ZOOM_W-1:0]    mul_b;
   logic                 mul_neg, mul_go;
   always_comb begin
      if (cmd.op == OP_MUL_OFFY) begin
         sum_sel = {min_y_ff[COORD_W-1], min_y_ff} + {max_y_ff[COORD_W-1], max_y_ff};
      end else begin
         sum_sel = {min_x_ff[COORD_W-1], min_x_ff} + {max_x_ff[COORD_W-1], max_x_ff};
      end
      w_sel = (cmd.op == OP_MUL_PIXY) ? wy_ff : wx_ff;
      w_abs = w_sel[COORD_W-1] ? (~w_sel + COORD_W'(1)) : w_sel;
      mul_go = 1'b0;
      mul_neg = sum_sel[COORD_W];
      mul_a = sum_sel[COORD_W] ? (~sum_sel + MUL_A_W'(1)) : sum_sel;
      mul_b = ztmp_ff;
      case (cmd.op)
         OP_MUL_OFFX, OP_MUL_OFFY: begin
            mul_go = 1'b1;
         end
         OP_MUL_PIXX, OP_MUL_PIXY: begin
            mul_go  = 1'b1;
            mul_neg = w_sel[COORD_W-1];
            mul_a   = MUL_A_W'(w_abs);
            mul_b   = scale_ff;
         end
         default: begin
            mul_go = 1'b0;
         end
      endcase
   end

   // Offset from product: size/2 - (sum*zoom)/2, saturated to 48 bits
   logic [PIX_W-1:0]   osize;
   logic [WIDE_W-1:0]  zc, szt, off_r;
   logic [WIDE_W-1:0]  smax, smin;
   logic [SHIFT_W-1:0] off_val;
   always_comb begin
      osize = (cmd.op == OP_COMMIT) ? cfg_height : cfg_width;
      zc    = WIDE_W'(prod_ff >> (FRAC_BITS + 1));
      szt   = WIDE_W'(osize) << (FRAC_BITS - 1);
      off_r = pneg_ff ? (szt + zc) : (szt - zc);
      smax  = {{(WIDE_W-SHIFT_W+1){1'b0}}, {(SHIFT_W-1){1'b1}}};
      smin  = {{(WIDE_W-SHIFT_W+1){1'b1}}, {(SHIFT_W-1){1'b0}}};
      if ($signed(off_r) > $signed(smax)) begin
         off_val = smax[SHIFT_W-1:0];
      end else if ($signed(off_r) < $signed(smin)) begin
         off_val = smin[SHIFT_W-1:0];
      end else begin
         off_val = off_r[SHIFT_W-1:0];
      end
   end

   // Pixel from product: trunc(zoom*p + offset), clamped to image
   logic [PIX_W-1:0]   psize;
   logic [SHIFT_W-1:0] pshift;
   logic [WIDE_W-1:0]  tw, pv, neg_lim, ip, last;
   logic [PIX_W-1:0]   pix_val;
   logic               pix_clamp;
   always_comb begin
      psize   = (cmd.op == OP_FIN_PIX) ? cfg_height : cfg_width;
      pshift  = (cmd.op == OP_FIN_PIX) ? shift_y_ff : shift_x_ff;
      tw      = WIDE_W'(prod_ff >> FRAC_BITS);
      pv      = (pneg_ff ? (~tw + WIDE_W'(1)) : tw) +
                {{(WIDE_W-SHIFT_W){pshift[SHIFT_W-1]}}, pshift};
      neg_lim = ~(WIDE_W'(1) << FRAC_BITS) + WIDE_W'(1);
      ip      = pv >> FRAC_BITS;
      last    = WIDE_W'(psize - PIX_W'(1));
      pix_val   = ip[PIX_W-1:0];
      pix_clamp = 1'b0;
      if ($signed(pv) <= $signed(neg_lim)) begin
         pix_val   = '0;
         pix_clamp = 1'b1;
      end else if (pv[WIDE_W-1]) begin
         pix_val = '0;
      end else if (psize == '0) begin
         pix_val   = '0;
         pix_clamp = 1'b1;
      end else if (ip > last) begin
         pix_val   = last[PIX_W-1:0];
         pix_clamp = 1'b1;
      end
   end

   // Latch the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         wx_ff     <= req_world_x;
         wy_ff     <= req_world_y;
         px_ff     <= req_pixel_x;
         py_ff     <= req_pixel_y;
      end
   end

   // Box and fit state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff   <= 32'sh7FFF_FFFF;
         min_y_ff   <= 32'sh7FFF_FFFF;
         max_x_ff   <= 32'sh8000_0000;
         max_y_ff   <= 32'sh8000_0000;
         scale_ff   <= '0;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         fitted_ff  <= 1'b0;
      end else if (cmd.op == OP_DECODE && action_ff == ACT_ADD) begin
         if (wx_ff < min_x_ff) min_x_ff <= wx_ff;
         if (wy_ff < min_y_ff) min_y_ff <= wy_ff;
         if (wx_ff > max_x_ff) max_x_ff <= wx_ff;
         if (wy_ff > max_y_ff) max_y_ff <= wy_ff;
      end else if (cmd.op == OP_DECODE && action_ff == ACT_CLEAR) begin
         min_x_ff   <= 32'sh7FFF_FFFF;
         min_y_ff   <= 32'sh7FFF_FFFF;
         max_x_ff   <= 32'sh8000_0000;
         max_y_ff   <= 32'sh8000_0000;
         scale_ff   <= '0;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         fitted_ff  <= 1'b0;
      end else if (cmd.op == OP_COMMIT) begin
         scale_ff   <= ztmp_ff;
         shift_x_ff <= shx_tmp_ff;
         shift_y_ff <= off_val;
         fitted_ff  <= 1'b1;
      end
   end

   // Work registers
   always_ff @(posedge clock) begin
      if (cmd.op == OP_DECODE) begin
         ztmp_ff <= {ZOOM_W{1'b1}};
      end else if (cmd.op == OP_TAKE_Z && qz < ztmp_ff) begin
         ztmp_ff <= qz;
      end
      if (cmd.op == OP_MUL_OFFY) begin
         shx_tmp_ff <= off_val;
      end
      if (mul_go) begin
         prod_ff <= mul_a * mul_b;
         pneg_ff <= mul_neg;
      end
      if (div_start) begin
         wneg_ff <= nneg;
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_DECODE: begin
            res_wx_ff <= '0;
            res_wy_ff <= '0;
            res_px_ff <= '0;
            res_py_ff <= '0;
            flag_ff   <= 1'b0;
            res_st_ff <= ST_OK;
            if (action_ff == ACT_FIT) begin
               if (bad_size) res_st_ff <= ST_BAD_SIZE;
               else if (empty) res_st_ff <= ST_EMPTY;
               else if (!ex_nz && !ey_nz) res_st_ff <= ST_DEGEN;
            end else if ((action_ff == ACT_W2P || action_ff == ACT_P2W) && !can_map) begin
               res_st_ff <= ST_NOT_FIT;
            end
         end
         OP_TAKE_WX: begin
            res_wx_ff <= w_val;
            flag_ff   <= w_sat;
         end
         OP_TAKE_WY: begin
            res_wy_ff <= w_val;
            res_st_ff <= (flag_ff || w_sat) ? ST_CLAMP : ST_OK;
         end
         OP_MUL_PIXY: begin
            res_px_ff <= pix_val;
            flag_ff   <= pix_clamp;
         end
         OP_FIN_PIX: begin
            res_py_ff <= pix_val;
            res_st_ff <= (flag_ff || pix_clamp) ? ST_CLAMP : ST_OK;
         end
         default: begin
            res_st_ff <= res_st_ff;
         end
      endcase
   end

   // Output stage: load on emit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_wx_ff <= res_wx_ff;
         rsp_wy_ff <= res_wy_ff;
         rsp_px_ff <= res_px_ff;
         rsp_py_ff <= res_py_ff;
         rsp_st_ff <= res_st_ff;
      end
   end

   always_comb begin
      sts.action   = action_ff;
      sts.bad_size = bad_size;
      sts.empty    = empty;
      sts.degen    = !ex_nz && !ey_nz;
      sts.ex_nz    = ex_nz;
      sts.ey_nz    = ey_nz;
      sts.can_map  = can_map;
      sts.div_done = div_done;
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_world_x = rsp_wx_ff;
   assign rsp_out_world_y = rsp_wy_ff;
   assign rsp_out_pixel_x = rsp_px_ff;
   assign rsp_out_pixel_y = rsp_py_ff;
   assign rsp_status      = rsp_st_ff;

   `FVT_ASSERT_IMPLY(a_fit_has_zoom, fitted_ff, scale_ff != '0)
   `FVT_ASSERT_IMPLY(a_no_overwrite, cmd.emit, !rsp_valid_ff || !rsp_stall)
   `FVT_ASSERT_IMPLY(a_div_idle_start, div_start, !div_busy)
   `FVT_ASSERT_NEXT(a_div_runs, div_start, div_busy)

endmodule

// File: design/fvt_ctrl.sv
// ----------------------------------------------------------------------------
// fvt_ctrl
// Sequencer: steps each action through the divider or multiplier as it needs, then the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvt_ctrl import fvt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      cmd.load  = 1'b0;
      cmd.emit  = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.op   = OP_DECODE;
            state_in = S_DONE;
            case (sts.action)
               ACT_FIT: begin
                  if (!(sts.bad_size || sts.empty || sts.degen)) begin
                     state_in = sts.ex_nz ? S_FIT_DX : S_FIT_DY;
                  end
               end
               ACT_W2P: begin
                  if (sts.can_map) state_in = S_W2P_MX;
               end
               ACT_P2W: begin
                  if (sts.can_map) state_in = S_P2W_DX;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_FIT_DX: begin
            cmd.op   = OP_DIV_ZX;
            state_in = S_FIT_WX;
         end
         S_FIT_WX: begin
            if (sts.div_done) begin
               cmd.op   = OP_TAKE_Z;
               state_in = sts.ey_nz ? S_FIT_DY : S_FIT_MX;
            end
         end
         S_FIT_DY: begin
            cmd.op   = OP_DIV_ZY;
            state_in = S_FIT_WY;
         end
         S_FIT_WY: begin
            if (sts.div_done) begin
               cmd.op   = OP_TAKE_Z;
               state_in = S_FIT_MX;
            end
         end
         S_FIT_MX: begin
            cmd.op   = OP_MUL_OFFX;
            state_in = S_FIT_MY;
         end
         S_FIT_MY: begin
            cmd.op   = OP_MUL_OFFY;
            state_in = S_FIT_COMMIT;
         end
         S_FIT_COMMIT: begin
            cmd.op   = OP_COMMIT;
            state_in = S_DONE;
         end
         S_W2P_MX: begin
            cmd.op   = OP_MUL_PIXX;
            state_in = S_W2P_MY;
         end
         S_W2P_MY: begin
            cmd.op   = OP_MUL_PIXY;
            state_in = S_W2P_FIN;
         end
         S_W2P_FIN: begin
            cmd.op   = OP_FIN_PIX;
            state_in = S_DONE;
         end
         S_P2W_DX: begin
            cmd.op   = OP_DIV_WX;
            state_in = S_P2W_WX;
         end
         S_P2W_WX: begin
            if (sts.div_done) begin
               cmd.op   = OP_TAKE_WX;
               state_in = S_P2W_DY;
            end
         end
         S_P2W_DY: begin
            cmd.op   = OP_DIV_WY;
            state_in = S_P2W_WY;
         end
         S_P2W_WY: begin
            if (sts.div_done) begin
               cmd.op   = OP_TAKE_WY;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: design/fit_to_viewport_transform.sv
// ----------------------------------------------------------------------------
// fit_to_viewport_transform
// Bounding box fit of Q.FRAC_BITS world points into an image, with world to
// pixel and pixel to world mapping. One item in flight at a time. Fit and
// pixel to world run their divisions in turn on the shared bit-serial
// divider, up to two for a fit and two for pixel to world. A stalled result
// holds the input off. Synchronous reset clears the registers, box, fit
// and control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fit_to_viewport_transform import fvt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ACT_W-1:0]          req_action,
   input  logic signed [COORD_W-1:0] req_world_x,
   input  logic signed [COORD_W-1:0] req_world_y,
   input  logic [PIX_W-1:0]          req_pixel_x,
   input  logic [PIX_W-1:0]          req_pixel_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_out_world_x,
   output logic signed [COORD_W-1:0] rsp_out_world_y,
   output logic [PIX_W-1:0]          rsp_out_pixel_x,
   output logic [PIX_W-1:0]          rsp_out_pixel_y,
   output logic [ST_W-1:0]           rsp_status,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_AW-1:0]         paddr,
   input  logic [CSR_DW-1:0]         pwdata,
   output logic [CSR_DW-1:0]         prdata,
   output logic                      pready
);

   logic [PIX_W-1:0]    width_ff, height_ff;
   logic [MARGIN_W-1:0] margin_ff;
   logic                csr_wr;
   dp_cmd_type          cmd;
   dp_sts_type          sts;

   // Register writes on the access beat
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         margin_ff <= '0;
      end else if (csr_wr) begin
         case (paddr[CSR_AW-1:2])
            REG_WIDTH:  width_ff  <= pwdata[PIX_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[PIX_W-1:0];
            REG_MARGIN: margin_ff <= pwdata[MARGIN_W-1:0];
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (paddr[CSR_AW-1:2])
         REG_WIDTH:  prdata = CSR_DW'(width_ff);
         REG_HEIGHT: prdata = CSR_DW'(height_ff);
         REG_MARGIN: prdata = CSR_DW'(margin_ff);
         default:    prdata = '0;
      endcase
   end

   fvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fvt_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_world_x     (req_world_x),
      .req_world_y     (req_world_y),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .cfg_width       (width_ff),
      .cfg_height      (height_ff),
      .cfg_margin      (margin_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_world_x (rsp_out_world_x),
      .rsp_out_world_y (rsp_out_world_y),
      .rsp_out_pixel_x (rsp_out_pixel_x),
      .rsp_out_pixel_y (rsp_out_pixel_y),
      .rsp_status      (rsp_status)
   );

endmodule
